// ----- sv/work_queue_admission_macros.svh -----
// ----------------------------------------------------------------------------
// work_queue_admission assertion macros
// Shared concurrent assertion helpers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef WORK_QUEUE_ADMISSION_MACROS_SVH
`define WORK_QUEUE_ADMISSION_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define WQA_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// next-cycle implication
`define WQA_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`else

`define WQA_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WQA_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- sv/wqa_pkg.sv -----
// ----------------------------------------------------------------------------
// wqa_pkg
// Types, codes and defaults shared by the work queue admission block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wqa_pkg;

  localparam int RING_DEPTH_DEF  = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int REQ_W    = 3;
  localparam int HANDLE_W = 64;
  localparam int QUEUED_W = 5;
  localparam int RUN_W    = 16;
  localparam int STAT_W   = 32;

  localparam int CAP_W      = 5;
  localparam int WORKERS_W  = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKERS  = 1'b1;

  localparam logic [CAP_W-1:0]     CAPACITY_RST = 5'd16;
  localparam logic [WORKERS_W-1:0] WORKERS_RST  = 8'd1;

  localparam logic [REQ_W-1:0] REQ_START    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_STOP     = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SUBMIT   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TAKE     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_COMPLETE = 3'd4;

  typedef enum logic [2:0] {
    STAT_OK            = 3'd0,
    STAT_FULL          = 3'd1,
    STAT_STOPPED       = 3'd2,
    STAT_INVALID       = 3'd3,
    STAT_START_REFUSED = 3'd4,
    STAT_EMPTY_WAIT    = 3'd5,
    STAT_EMPTY_EXIT    = 3'd6,
    STAT_NONE_RUNNING  = 3'd7
  } status_t;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [HANDLE_W-1:0] job_handle;
    logic [HANDLE_W-1:0] job_argument;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] taken_handle;
    logic [HANDLE_W-1:0] taken_argument;
    logic [QUEUED_W-1:0] queued_now;
    logic [RUN_W-1:0]    running_now;
    logic [STAT_W-1:0]   accepted_total;
    logic [STAT_W-1:0]   completed_total;
    logic [STAT_W-1:0]   full_rejects;
    logic [STAT_W-1:0]   stopped_rejects;
    logic [STAT_W-1:0]   invalid_rejects;
    logic                accepting_now;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } dp_cmd_t;

endpackage

// ----- sv/wqa_ram.sv -----
// ----------------------------------------------------------------------------
// wqa_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wqa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/wqa_ctrl.sv -----
// ----------------------------------------------------------------------------
// wqa_ctrl
// Request sequencer: capture a request, execute it, strobe the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wqa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output wqa_pkg::dp_cmd_t cmd
);

  import wqa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
    end
  end

  assign busy        = (state != S_IDLE);
  assign cmd.capture = (state == S_IDLE) && start;
  assign cmd.execute = (state == S_EXEC);

endmodule

// ----- sv/wqa_dp.sv -----
// ----------------------------------------------------------------------------
// wqa_dp
// Descriptor ring, admission flags, statistics counters and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wqa_dp #(
  parameter int RING_DEPTH  = wqa_pkg::RING_DEPTH_DEF,
  parameter int COUNT_WIDTH = wqa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  wqa_pkg::dp_cmd_t                   cmd,
  input  wqa_pkg::req_t                      req,
  input  logic                               cfg_we,
  input  logic [wqa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wqa_pkg::CFG_DATA_W-1:0]     cfg_data,
  output wqa_pkg::result_t                   result
);

  import wqa_pkg::*;

  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = IDX_W + 1;
  localparam int CMP_W  = (FILL_W > CAP_W) ? FILL_W : CAP_W;
  localparam int OUT_CW = (COUNT_WIDTH > STAT_W) ? COUNT_WIDTH : STAT_W;
  localparam int SLOT_W = 2 * HANDLE_W;

  // configuration
  logic [CAP_W-1:0]     capacity;
  logic [WORKERS_W-1:0] workers;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RST;
      workers  <= WORKERS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY: capacity <= cfg_data[CAP_W-1:0];
        CFG_WORKERS:  workers  <= cfg_data[WORKERS_W-1:0];
        default: ;
      endcase
    end
  end

  // captured request
  req_t req_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
    end
  end

  // ring state
  logic [IDX_W-1:0]       head, head_next;
  logic [FILL_W-1:0]      fill, fill_next;
  logic [RUN_W-1:0]       run, run_next;
  logic [COUNT_WIDTH-1:0] acc, acc_next;
  logic [COUNT_WIDTH-1:0] fin, fin_next;
  logic [COUNT_WIDTH-1:0] fullc, fullc_next;
  logic [COUNT_WIDTH-1:0] stopc, stopc_next;
  logic [COUNT_WIDTH-1:0] invc, invc_next;
  logic                   tried, tried_next;
  logic                   open, open_next;
  logic                   halt, halt_next;

  status_t                stat;
  logic                   take_hit;
  logic                   push;

  logic [CMP_W-1:0]       cap_ext, cap_eff, fill_ext, fill_next_ext;
  logic [SUM_W-1:0]       tail_sum, tail_wrap;
  logic [IDX_W-1:0]       head_inc;
  logic [SLOT_W-1:0]      slot_rd;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign cap_ext  = CMP_W'(capacity);
  assign cap_eff  = (cap_ext > CMP_W'(RING_DEPTH)) ? CMP_W'(RING_DEPTH) : cap_ext;
  assign fill_ext = CMP_W'(fill);

  // tail = (head + fill) mod depth, sum stays below twice the depth
  assign tail_sum  = SUM_W'(head) + SUM_W'(fill);
  assign tail_wrap = (tail_sum >= SUM_W'(RING_DEPTH)) ? tail_sum - SUM_W'(RING_DEPTH)
                                                      : tail_sum;
  assign head_inc  = (head == IDX_W'(RING_DEPTH - 1)) ? '0 : head + 1'b1;

  wqa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (RING_DEPTH),
    .AW    (IDX_W)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.execute && push),
    .waddr (tail_wrap[IDX_W-1:0]),
    .wdata ({req_q.job_handle, req_q.job_argument}),
    .raddr (head),
    .rdata (slot_rd)
  );

  always_comb begin
    head_next  = head;
    fill_next  = fill;
    run_next   = run;
    acc_next   = acc;
    fin_next   = fin;
    fullc_next = fullc;
    stopc_next = stopc;
    invc_next  = invc;
    tried_next = tried;
    open_next  = open;
    halt_next  = halt;
    stat       = STAT_OK;
    take_hit   = 1'b0;
    push       = 1'b0;
    case (req_q.req_type)
      REQ_START: begin
        if (tried || halt || (workers == '0) || (cap_eff == '0)) begin
          stat = STAT_START_REFUSED;
        end else begin
          tried_next = 1'b1;
          open_next  = 1'b1;
        end
      end
      REQ_STOP: begin
        open_next = 1'b0;
        halt_next = 1'b1;
      end
      REQ_SUBMIT: begin
        if ((req_q.job_handle == '0) || (req_q.job_argument == '0)) begin
          invc_next = sat_inc(invc);
          stat      = STAT_INVALID;
        end else if (!open || halt) begin
          stopc_next = sat_inc(stopc);
          stat       = STAT_STOPPED;
        end else if (fill_ext >= cap_eff) begin
          fullc_next = sat_inc(fullc);
          stat       = STAT_FULL;
        end else begin
          push      = 1'b1;
          fill_next = fill + 1'b1;
          acc_next  = sat_inc(acc);
        end
      end
      REQ_TAKE: begin
        if (fill == '0) begin
          stat = halt ? STAT_EMPTY_EXIT : STAT_EMPTY_WAIT;
        end else begin
          take_hit  = 1'b1;
          head_next = head_inc;
          fill_next = fill - 1'b1;
          if (!(&run)) begin
            run_next = run + 1'b1;
          end
        end
      end
      REQ_COMPLETE: begin
        // a saturated running count still counts down
        if (run == '0) begin
          stat = STAT_NONE_RUNNING;
        end else begin
          run_next = run - 1'b1;
          fin_next = sat_inc(fin);
        end
      end
      default: begin
        stat = STAT_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      fill  <= '0;
      run   <= '0;
      acc   <= '0;
      fin   <= '0;
      fullc <= '0;
      stopc <= '0;
      invc  <= '0;
      tried <= 1'b0;
      open  <= 1'b0;
      halt  <= 1'b0;
    end else if (cmd.execute) begin
      head  <= head_next;
      fill  <= fill_next;
      run   <= run_next;
      acc   <= acc_next;
      fin   <= fin_next;
      fullc <= fullc_next;
      stopc <= stopc_next;
      invc  <= invc_next;
      tried <= tried_next;
      open  <= open_next;
      halt  <= halt_next;
    end
  end

  // result register
  logic [OUT_CW-1:0] acc_out, fin_out, fullc_out, stopc_out, invc_out;

  assign fill_next_ext = CMP_W'(fill_next);
  assign acc_out       = OUT_CW'(acc_next);
  assign fin_out       = OUT_CW'(fin_next);
  assign fullc_out     = OUT_CW'(fullc_next);
  assign stopc_out     = OUT_CW'(stopc_next);
  assign invc_out      = OUT_CW'(invc_next);

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      result.status          <= stat;
      result.taken_handle    <= take_hit ? slot_rd[SLOT_W-1:HANDLE_W] : '0;
      result.taken_argument  <= take_hit ? slot_rd[HANDLE_W-1:0] : '0;
      result.queued_now      <= fill_next_ext[QUEUED_W-1:0];
      result.running_now     <= run_next;
      result.accepted_total  <= acc_out[STAT_W-1:0];
      result.completed_total <= fin_out[STAT_W-1:0];
      result.full_rejects    <= fullc_out[STAT_W-1:0];
      result.stopped_rejects <= stopc_out[STAT_W-1:0];
      result.invalid_rejects <= invc_out[STAT_W-1:0];
      result.accepting_now   <= open_next;
    end
  end

endmodule

// ----- sv/work_queue_admission.sv -----
// ----------------------------------------------------------------------------
// work_queue_admission
// Bounded work descriptor queue with admission control and statistics.
// ----------------------------------------------------------------------------
//
// channel   | direction | handshake                    | beat
// ----------+-----------+------------------------------+-------------------
// request   | in        | start high while busy low    | req (req_t)
// result    | out       | done strobe, one cycle       | result (result_t)
// config    | in        | cfg_we high                  | cfg_index, cfg_data
//
// each request has a capture cycle that also reads the ring head
// from the descriptor memory (registered read), then an execute cycle; the
// result beat shows the cycle after, while the next request may be captured.
// a new request is captured only while busy is low. synchronous reset
// clears all control state and counters; ring contents are left as they are,
// no clearing pass. the receiver cannot stall the result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "work_queue_admission_macros.svh"

module work_queue_admission #(
  parameter int RING_DEPTH  = wqa_pkg::RING_DEPTH_DEF,
  parameter int COUNT_WIDTH = wqa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  wqa_pkg::req_t                  req,
  output logic                           done,
  output wqa_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [wqa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wqa_pkg::CFG_DATA_W-1:0] cfg_data
);

  import wqa_pkg::*;

  dp_cmd_t cmd;

  wqa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  wqa_dp #(
    .RING_DEPTH  (RING_DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

  `WQA_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `WQA_ASSERT_NXT(a_exec_done, clk, rst, busy, done && !busy)
  `WQA_ASSERT_IMP(a_done_after_exec, clk, rst, done, $past(busy))
  `WQA_ASSERT_IMP(a_taken_ok, clk, rst, done && (|result.taken_handle), result.status == STAT_OK)

endmodule
